// ===== rtl/core/cnmi_pkg.sv =====
// Shared constants, types and preference functions for the CNMI range list parser.
package cnmi_pkg;

    localparam int FIELD_COUNT = 5;
    localparam int FIELD_W     = $clog2(FIELD_COUNT + 1);
    localparam int MASK_W      = 10;
    localparam int OUT_FIELDS  = 5;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [MASK_W-1:0] mask_t;

    function automatic mask_t range_bits(input logic [3:0] lo, input logic [3:0] hi);
        mask_t m;
        m = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            m[i] = (4'(i) >= lo) && (4'(i) <= hi);
        end
        return m;
    endfunction

    // preference 2, 3, 1, 0
    function automatic logic [1:0] pick_mode(input mask_t m);
        logic [1:0] r;
        if (m[2])
            r = 2'd2;
        else if (m[3])
            r = 2'd3;
        else if (m[1])
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    // preference 1, 0
    function automatic logic pick_deliver(input mask_t m);
        return m[1];
    endfunction

    // preference 2, 3, 0, 1
    function automatic logic [1:0] pick_broadcast(input mask_t m);
        logic [1:0] r;
        if (m[2])
            r = 2'd2;
        else if (m[3])
            r = 2'd3;
        else if (m[0])
            r = 2'd0;
        else if (m[1])
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    // preference 0, 1
    function automatic logic pick_low_first(input mask_t m);
        return !m[0] && m[1];
    endfunction

endpackage

// ===== rtl/core/cnmi_range_list_parser.sv =====
// Top level of the CNMI supported-values range list parser.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | char_code, end_of_line
//  out     | output    | out_valid/out_stall | five choices, five masks
//
// One character is accepted per cycle while in_stall is low; the parse state updates in that cycle.
// The result for an end beat is registered on the output in the cycle after it is accepted.
// in_stall rises only while a result is held and out_stall is high.
// Reset clears the field index, bracket flag, look-ahead and all masks.
module cnmi_range_list_parser
    import cnmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  mode_choice,
    output logic        deliver_choice,
    output logic [1:0]  broadcast_choice,
    output logic        report_choice,
    output logic        buffer_choice,
    output logic [9:0]  mode_mask,
    output logic [9:0]  deliver_mask,
    output logic [9:0]  broadcast_mask,
    output logic [9:0]  report_mask,
    output logic [9:0]  buffer_mask
);

    typedef enum logic [1:0] {PH_NONE, PH_HELD, PH_DASH} phase_t;

    logic [FIELD_W-1:0] field_reg, field_next;
    logic               paren_reg, paren_next;
    phase_t             phase_reg, phase_next;
    logic [3:0]         held_reg, held_next;
    mask_t              masks_reg [FIELD_COUNT];
    mask_t              masks_next [FIELD_COUNT];
    mask_t              emit [OUT_FIELDS];

    logic        out_valid_reg;
    logic [1:0]  mode_choice_reg, broadcast_choice_reg;
    logic        deliver_choice_reg, report_choice_reg, buffer_choice_reg;
    mask_t       out_mask_reg [OUT_FIELDS];

    logic        accept;
    logic        is_digit;
    logic [3:0]  dval;
    logic        plain_en;
    logic        set_en;
    mask_t       set_bits;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_digit = char_code inside {[CH_ZERO:CH_NINE]};
    assign dval     = char_code[3:0];

    always_comb
    begin
        field_next = field_reg;
        paren_next = paren_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        plain_en   = 1'b0;
        set_en     = 1'b0;
        set_bits   = '0;
        for (int i = 0; i < FIELD_COUNT; i++)
        begin
            masks_next[i] = masks_reg[i];
        end

        case (phase_reg)
            PH_HELD:
            begin
                if (char_code == CH_DASH && !end_of_line)
                begin
                    phase_next = PH_DASH;
                end
                else
                begin
                    set_en     = 1'b1;
                    set_bits   = range_bits(held_reg, held_reg);
                    phase_next = PH_NONE;
                    plain_en   = 1'b1;
                end
            end
            PH_DASH:
            begin
                phase_next = PH_NONE;
                set_en     = 1'b1;
                if (is_digit)
                begin
                    set_bits = range_bits(held_reg, dval);
                end
                else
                begin
                    set_bits = range_bits(held_reg, held_reg);
                    plain_en = 1'b1;
                end
            end
            default:
            begin
                plain_en = 1'b1;
            end
        endcase

        if (plain_en && paren_reg && is_digit && end_of_line
            && (field_reg < FIELD_W'(FIELD_COUNT)))
        begin
            set_en   = 1'b1;
            set_bits = set_bits | range_bits(dval, dval);
        end

        if (set_en)
        begin
            for (int i = 0; i < FIELD_COUNT; i++)
            begin
                if (field_reg == FIELD_W'(i))
                begin
                    masks_next[i] = masks_reg[i] | set_bits;
                end
            end
        end

        if (plain_en && (field_reg < FIELD_W'(FIELD_COUNT)))
        begin
            if (char_code == CH_OPEN)
            begin
                paren_next = 1'b1;
            end
            else if (char_code == CH_COMMA)
            begin
                if (!paren_reg)
                    field_next = FIELD_W'(field_reg + 1'b1);
            end
            else if (char_code == CH_CLOSE)
            begin
                paren_next = 1'b0;
            end
            else if (paren_reg && is_digit && !end_of_line)
            begin
                held_next  = dval;
                phase_next = PH_HELD;
            end
        end

        for (int i = 0; i < OUT_FIELDS; i++)
        begin
            emit[i] = (i < FIELD_COUNT) ? masks_next[i % FIELD_COUNT] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg     <= '0;
            paren_reg     <= 1'b0;
            phase_reg     <= PH_NONE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FIELD_COUNT; i++)
            begin
                masks_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                if (end_of_line)
                begin
                    field_reg <= '0;
                    paren_reg <= 1'b0;
                    phase_reg <= PH_NONE;
                    held_reg  <= '0;
                    for (int i = 0; i < FIELD_COUNT; i++)
                    begin
                        masks_reg[i] <= '0;
                    end
                end
                else
                begin
                    field_reg <= field_next;
                    paren_reg <= paren_next;
                    phase_reg <= phase_next;
                    held_reg  <= held_next;
                    for (int i = 0; i < FIELD_COUNT; i++)
                    begin
                        masks_reg[i] <= masks_next[i];
                    end
                end
            end

            if (accept && end_of_line)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_line)
        begin
            mode_choice_reg      <= pick_mode(emit[0]);
            deliver_choice_reg   <= pick_deliver(emit[1]);
            broadcast_choice_reg <= pick_broadcast(emit[2]);
            report_choice_reg    <= pick_low_first(emit[3]);
            buffer_choice_reg    <= pick_low_first(emit[4]);
            for (int i = 0; i < OUT_FIELDS; i++)
            begin
                out_mask_reg[i] <= emit[i];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign mode_choice      = mode_choice_reg;
    assign deliver_choice   = deliver_choice_reg;
    assign broadcast_choice = broadcast_choice_reg;
    assign report_choice    = report_choice_reg;
    assign buffer_choice    = buffer_choice_reg;
    assign mode_mask        = out_mask_reg[0];
    assign deliver_mask     = out_mask_reg[1];
    assign broadcast_mask   = out_mask_reg[2];
    assign report_mask      = out_mask_reg[3];
    assign buffer_mask      = out_mask_reg[4];

endmodule

// ===== rtl/core/cnmi_checker.sv =====
// Port-level assertions for the CNMI range list parser, with their bind.
module cnmi_checker
    import cnmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        end_of_line,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  mode_choice,
    input  logic        report_choice,
    input  logic [9:0]  mode_mask,
    input  logic [9:0]  report_mask
);

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result held");

    a_end_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_line |=> out_valid)
        else $error("end beat produced no result");

    a_mode_choice_listed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_choice != 2'd0 |-> mode_mask[mode_choice])
        else $error("mode choice not in its mask");

    a_report_prefers_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_mask[0] |-> !report_choice)
        else $error("report choice ignores preferred value");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mode_mask))
        else $error("stalled result changed");

endmodule

bind cnmi_range_list_parser cnmi_checker u_cnmi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_line   (end_of_line),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mode_choice   (mode_choice),
    .report_choice (report_choice),
    .mode_mask     (mode_mask),
    .report_mask   (report_mask)
);

// ===== tb/cnmi_range_list_parser_tb.sv =====
// Self-checking testbench for the CNMI range list parser, driven with directed and random lines.
`timescale 1ns / 100ps

module cnmi_range_list_parser_tb;
    import cnmi_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_CHARS   = 850;
    localparam int REPORT_LIMIT   = 10;
    localparam int MASK_SLOTS     = 8;

    typedef bit [7:0] char_q_t[$];

    typedef enum bit [1:0] {LOOK_NONE, LOOK_DIGIT, LOOK_DASH} look_t;

    typedef struct packed {
        logic [1:0] mode_choice;
        logic       deliver_choice;
        logic [1:0] broadcast_choice;
        logic       report_choice;
        logic       buffer_choice;
        logic [9:0] mode_mask;
        logic [9:0] deliver_mask;
        logic [9:0] broadcast_mask;
        logic [9:0] report_mask;
        logic [9:0] buffer_mask;
    } line_result_t;

    class cnmi_line_checker;
        int unsigned  field_idx;
        bit           in_group;
        look_t        look;
        bit [3:0]     held;
        bit [9:0]     masks[MASK_SLOTS];
        line_result_t expected_lines[$];
        int unsigned  mismatches;
        int unsigned  failures;

        function new();
            clear_line();
            mismatches = 0;
            failures   = 0;
        endfunction

        function void clear_line();
            field_idx = 0;
            in_group  = 1'b0;
            look      = LOOK_NONE;
            held      = '0;
            foreach (masks[i])
            begin
                masks[i] = '0;
            end
        endfunction

        function bit is_digit(bit [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void mark(int unsigned lo, int unsigned hi);
            if (field_idx >= FIELD_COUNT || field_idx >= MASK_SLOTS)
                return;
            for (int unsigned v = lo; v <= hi && v < 10; v++)
            begin
                masks[field_idx][v] = 1'b1;
            end
        endfunction

        function void plain(bit [7:0] c, bit last);
            if (field_idx >= FIELD_COUNT)
                return;
            if (c == CH_OPEN)
                in_group = 1'b1;
            else if (c == CH_COMMA)
            begin
                if (!in_group)
                    field_idx++;
            end
            else if (c == CH_CLOSE)
                in_group = 1'b0;
            else if (in_group && is_digit(c))
            begin
                if (last)
                    mark(32'(c - CH_ZERO), 32'(c - CH_ZERO));
                else
                begin
                    held = 4'(c - CH_ZERO);
                    look = LOOK_DIGIT;
                end
            end
        endfunction

        function int unsigned pick(bit [9:0] m, int unsigned order[4], int unsigned n);
            for (int unsigned i = 0; i < n; i++)
            begin
                if (m[order[i]])
                    return order[i];
            end
            return 0;
        endfunction

        function bit [9:0] field_mask(int unsigned i);
            if (i >= FIELD_COUNT || i >= MASK_SLOTS)
                return '0;
            return masks[i];
        endfunction

        function void take_char(bit [7:0] c, bit last);
            line_result_t r;
            case (look)
                LOOK_DIGIT:
                begin
                    if (c == CH_DASH && !last)
                        look = LOOK_DASH;
                    else
                    begin
                        mark(32'(held), 32'(held));
                        look = LOOK_NONE;
                        plain(c, last);
                    end
                end
                LOOK_DASH:
                begin
                    look = LOOK_NONE;
                    if (is_digit(c))
                        mark(32'(held), 32'(c - CH_ZERO));
                    else
                    begin
                        mark(32'(held), 32'(held));
                        plain(c, last);
                    end
                end
                default:
                    plain(c, last);
            endcase
            if (last)
            begin
                r.mode_mask        = field_mask(0);
                r.deliver_mask     = field_mask(1);
                r.broadcast_mask   = field_mask(2);
                r.report_mask      = field_mask(3);
                r.buffer_mask      = field_mask(4);
                r.mode_choice      = 2'(pick(r.mode_mask, '{2, 3, 1, 0}, 4));
                r.deliver_choice   = 1'(pick(r.deliver_mask, '{1, 0, 0, 0}, 2));
                r.broadcast_choice = 2'(pick(r.broadcast_mask, '{2, 3, 0, 1}, 4));
                r.report_choice    = 1'(pick(r.report_mask, '{0, 1, 0, 0}, 2));
                r.buffer_choice    = 1'(pick(r.buffer_mask, '{0, 1, 0, 0}, 2));
                expected_lines.push_back(r);
                clear_line();
            end
        endfunction

        function void compare(string name, logic [9:0] want, logic [9:0] got);
            if (want !== got)
            begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_line(line_result_t got);
            line_result_t want;
            if (expected_lines.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result beat with no line pending", $time);
                return;
            end
            want = expected_lines.pop_front();
            compare("mode_choice", 10'(want.mode_choice), 10'(got.mode_choice));
            compare("deliver_choice", 10'(want.deliver_choice), 10'(got.deliver_choice));
            compare("broadcast_choice", 10'(want.broadcast_choice),
                    10'(got.broadcast_choice));
            compare("report_choice", 10'(want.report_choice), 10'(got.report_choice));
            compare("buffer_choice", 10'(want.buffer_choice), 10'(got.buffer_choice));
            compare("mode_mask", want.mode_mask, got.mode_mask);
            compare("deliver_mask", want.deliver_mask, got.deliver_mask);
            compare("broadcast_mask", want.broadcast_mask, got.broadcast_mask);
            compare("report_mask", want.report_mask, got.report_mask);
            compare("buffer_mask", want.buffer_mask, got.buffer_mask);
        endfunction

        function int unsigned pending();
            return expected_lines.size();
        endfunction
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] char_code   = 8'h00;
    logic       end_of_line = 1'b0;
    logic       out_stall   = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] mode_choice;
    logic       deliver_choice;
    logic [1:0] broadcast_choice;
    logic       report_choice;
    logic       buffer_choice;
    logic [9:0] mode_mask;
    logic [9:0] deliver_mask;
    logic [9:0] broadcast_mask;
    logic [9:0] report_mask;
    logic [9:0] buffer_mask;

    cnmi_line_checker line_checker;
    line_result_t     seen_line;
    int unsigned      burst_left = 0;
    int unsigned      stall_mode = 0;
    int unsigned      stall_left = 0;

    cnmi_range_list_parser u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .end_of_line      (end_of_line),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mode_choice      (mode_choice),
        .deliver_choice   (deliver_choice),
        .broadcast_choice (broadcast_choice),
        .report_choice    (report_choice),
        .buffer_choice    (buffer_choice),
        .mode_mask        (mode_mask),
        .deliver_mask     (deliver_mask),
        .broadcast_mask   (broadcast_mask),
        .report_mask      (report_mask),
        .buffer_mask      (buffer_mask)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_line = '{mode_choice, deliver_choice, broadcast_choice, report_choice,
                          buffer_choice, mode_mask, deliver_mask, broadcast_mask,
                          report_mask, buffer_mask};
            line_checker.check_line(seen_line);
        end
    end

    function automatic void add_text(ref char_q_t q, input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            q.push_back(s[i]);
        end
    endfunction

    function automatic bit [7:0] noise_char();
        string alphabet = "(),-0123456789 x";
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    function automatic void make_line(ref char_q_t q);
        int unsigned kind;
        int unsigned nf;
        int unsigned ni;
        int unsigned a;
        int unsigned b;
        int unsigned cut;
        q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 30))
            begin
                q.push_back(noise_char());
            end
            return;
        end
        if ($urandom_range(0, 3) == 0)
            add_text(q, "+CNMI: ");
        nf = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 5;
        for (int unsigned f = 0; f < nf; f++)
        begin
            if (f > 0)
                q.push_back(CH_COMMA);
            q.push_back(CH_OPEN);
            ni = $urandom_range(0, 3);
            for (int unsigned j = 0; j < ni; j++)
            begin
                if (j > 0)
                    q.push_back(CH_COMMA);
                a = $urandom_range(0, 9);
                q.push_back(8'(CH_ZERO + a));
                if ($urandom_range(0, 2) == 0)
                begin
                    b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : $urandom_range(a, 9);
                    q.push_back(CH_DASH);
                    q.push_back(8'(CH_ZERO + b));
                end
            end
            q.push_back(CH_CLOSE);
        end
        if (kind <= 2)
        begin
            repeat ($urandom_range(0, 3))
            begin
                q[$urandom_range(0, q.size() - 1)] = noise_char();
            end
            cut = $urandom_range(1, q.size());
            while (q.size() > cut)
                q.pop_back();
        end
        else if (kind == 3)
        begin
            repeat ($urandom_range(1, 6))
            begin
                q.push_back(noise_char());
            end
        end
    endfunction

    task automatic send_char(input bit [7:0] c, input bit last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 10);
        end
        in_valid    <= 1'b1;
        char_code   <= c;
        end_of_line <= last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        line_checker.take_char(c, last);
        burst_left--;
    endtask

    task automatic send_line(input char_q_t q);
        foreach (q[i])
        begin
            send_char(q[i], i == q.size() - 1);
        end
    endtask

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL cnmi_range_list_parser");
        $finish;
    end

    initial
    begin
        char_q_t     line;
        int unsigned sent_chars;
        line_checker = new();
        sent_chars   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        line.delete();
        line.push_back(8'h00);
        send_line(line);
        line.delete();
        add_text(line, "(3-");
        send_line(line);
        line.delete();
        add_text(line, "(9-1-7");
        send_line(line);
        line.delete();
        add_text(line, "5(2-");
        line.push_back(8'hFF);
        add_text(line, "),,,,,(4");
        send_line(line);

        while (sent_chars < RANDOM_CHARS)
        begin
            make_line(line);
            send_line(line);
            sent_chars += line.size();
        end
        in_valid <= 1'b0;

        while (line_checker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (line_checker.failures == 0)
            $display("PASS cnmi_range_list_parser");
        else
            $display("FAIL cnmi_range_list_parser");
        $finish;
    end

endmodule
